@@ hw/rtl/hctd_pkg.sv @@
// shared types and constants for the huffman code table decoder
package hctd_pkg;

  localparam int CODE_BITS_DEF = 15;
  localparam int ID_W          = 15;
  localparam int SYM_W         = 8;
  localparam int ENTRY_W       = SYM_W + 1;
  localparam int IN_DATA_W     = 24;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

@@ hw/rtl/hctd_table.sv @@
// single-port code table memory: valid flag and symbol byte per entry
module hctd_table #(
  parameter int CODE_BITS = hctd_pkg::CODE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic                        re,
  input  logic [CODE_BITS-1:0]        addr,
  input  logic [hctd_pkg::ENTRY_W-1:0] wdata,
  output logic [hctd_pkg::ENTRY_W-1:0] rdata
);

  localparam int Depth = 2 ** CODE_BITS;

  logic [hctd_pkg::ENTRY_W-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ hw/rtl/huffman_code_table_decoder.sv @@
// top level of the huffman code table decoder
//
// bit-serial huffman decoder over a directly indexed code table. a load beat
// (s_tuser = 0) stores a symbol byte at a code id, the code bits behind a
// leading 1, and marks that entry valid. a decode beat (s_tuser = 1) shifts
// one stream bit into a path register that starts at 1; when the path runs
// past the table an error beat goes out (symbol 0, m_tuser = 1) and the path
// returns to 1, and when the table entry at the path is valid its symbol goes
// out and the path returns to 1. a load is written straight into the table; a
// decode does a synchronous read of the entry at the new path, which every bit
// needs before the path can move on, and waits in the lookup state while the
// output register is full. the result sits in that register, so the next beat
// is taken while it waits. after reset the block sweeps the table once to clear
// all valid flags, one entry a cycle, with s_tready low.
module huffman_code_table_decoder #(
  parameter int CODE_BITS = hctd_pkg::CODE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // code_id [14:0], symbol [22:15], bit_req [23]
  input  logic [hctd_pkg::IN_DATA_W-1:0]  s_tdata,
  // command [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // decoded_symbol [7:0]
  output logic [hctd_pkg::SYM_W-1:0]      m_tdata,
  // code_error [0]
  output logic                            m_tuser
);

  localparam int IdW  = hctd_pkg::ID_W;
  localparam int SymW = hctd_pkg::SYM_W;

  // input beat fields
  logic [IdW-1:0]  code_id;
  logic [SymW-1:0] symbol;
  logic            bit_req;

  assign code_id = s_tdata[IdW-1:0];
  assign symbol  = s_tdata[IdW+SymW-1:IdW];
  assign bit_req = s_tdata[IdW+SymW];

  // control registers
  hctd_pkg::state_t     state, state_next;
  logic [CODE_BITS-1:0] clr_addr, clr_addr_next;
  logic [CODE_BITS-1:0] path, path_next;
  logic                 ovf, ovf_next;
  logic                 out_valid_next;

  // output payload
  logic [SymW-1:0] out_sym, out_sym_next;
  logic            out_err, out_err_next;
  logic            out_load;

  // table port
  logic                          mem_we;
  logic                          mem_re;
  logic [CODE_BITS-1:0]          mem_addr;
  logic [hctd_pkg::ENTRY_W-1:0]  mem_wdata;
  logic [hctd_pkg::ENTRY_W-1:0]  mem_rdata;

  // load address check: ids at or above the table size are dropped
  logic [IdW+CODE_BITS-1:0] id_ext;
  logic                     id_in_range;
  logic [CODE_BITS-1:0]     load_addr;

  assign id_ext      = {{CODE_BITS{1'b0}}, code_id};
  assign id_in_range = (id_ext[IdW+CODE_BITS-1:CODE_BITS] == '0);
  assign load_addr   = id_ext[CODE_BITS-1:0];

  // path after shifting in the new bit; top bit set means it left the table
  logic [CODE_BITS:0] path_shift;
  assign path_shift = {path, bit_req};

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  logic entry_hit;
  assign entry_hit = mem_rdata[hctd_pkg::ENTRY_W-1];

  hctd_table #(
    .CODE_BITS (CODE_BITS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    path_next     = path;
    ovf_next      = ovf;
    out_sym_next  = out_sym;
    out_err_next  = out_err;
    out_load      = 1'b0;
    s_tready      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = load_addr;
    mem_wdata     = {1'b1, symbol};

    unique case (state)
      hctd_pkg::ST_CLEAR: begin
        // sweep the table, dropping every valid flag
        mem_we        = 1'b1;
        mem_addr      = clr_addr;
        mem_wdata     = '0;
        clr_addr_next = clr_addr + CODE_BITS'(1);
        if (clr_addr == {CODE_BITS{1'b1}}) begin
          state_next = hctd_pkg::ST_IDLE;
        end
      end
      hctd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == hctd_pkg::CMD_LOAD) begin
            mem_we = id_in_range;
          end else begin
            // read the entry at the new path; result is decided next cycle
            mem_re     = 1'b1;
            mem_addr   = path_shift[CODE_BITS-1:0];
            path_next  = path_shift[CODE_BITS-1:0];
            ovf_next   = path_shift[CODE_BITS];
            state_next = hctd_pkg::ST_LOOKUP;
          end
        end
      end
      hctd_pkg::ST_LOOKUP: begin
        if (ovf || entry_hit) begin
          // a result is due; wait for room in the output register
          if (out_free) begin
            out_load     = 1'b1;
            out_err_next = ovf;
            out_sym_next = ovf ? '0 : mem_rdata[SymW-1:0];
            path_next    = CODE_BITS'(1);
            state_next   = hctd_pkg::ST_IDLE;
          end
        end else begin
          // code not complete yet, keep the path
          state_next = hctd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hctd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hctd_pkg::ST_CLEAR;
      clr_addr <= '0;
      path     <= CODE_BITS'(1);
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      path     <= path_next;
      ovf      <= ovf_next;
      m_tvalid <= out_valid_next;
    end
  end

  // output payload, loaded only when a result is produced
  always_ff @(posedge clk) begin
    out_sym <= out_sym_next;
    out_err <= out_err_next;
  end

  assign m_tdata = out_sym;
  assign m_tuser = out_err;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the huffman code table decoder
module testbench;

  localparam int CODE_BITS_DEF = hctd_pkg::CODE_BITS_DEF;
  localparam int ID_W          = hctd_pkg::ID_W;
  localparam int SYM_W         = hctd_pkg::SYM_W;
  localparam int IN_DATA_W     = hctd_pkg::IN_DATA_W;

  localparam int TBL_SIZE  = 1 << CODE_BITS_DEF;
  localparam int HOLD_LEN  = 300;  // long receiver hold-off, in cycles
  localparam int TAIL_WAIT = 20;   // cycles to idle after the last result
  localparam int N_ITEMS   = 400;

  // one output beat: symbol byte plus the overflow flag
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             err;
  } decode_result_t;

  // tracks the code table and the bit path, and holds the symbols still owed
  class decode_scoreboard;
    bit [SYM_W-1:0]      sym_mem [0:TBL_SIZE-1];
    bit                  entry_set [0:TBL_SIZE-1];
    bit [CODE_BITS_DEF:0] path_reg;
    decode_result_t      owed_q[$];
    int n_fail, n_load, n_decode, n_sym, n_err;

    function new();
      foreach (entry_set[i]) entry_set[i] = 1'b0;
      path_reg = 1;
    endfunction

    // an input beat was accepted: update the table or walk the path
    function void note_beat(logic cmd, logic [IN_DATA_W-1:0] data);
      logic [ID_W-1:0]  id;
      logic [SYM_W-1:0] sym;
      logic             stream_bit;
      decode_result_t   res;
      id         = data[ID_W-1:0];
      sym        = data[ID_W+SYM_W-1:ID_W];
      stream_bit = data[IN_DATA_W-1];
      if (cmd == hctd_pkg::CMD_LOAD) begin
        n_load++;
        // ids past the table are dropped (only possible for narrow tables)
        if (int'(id) < TBL_SIZE) begin
          sym_mem[id]   = sym;
          entry_set[id] = 1'b1;
        end
      end else begin
        n_decode++;
        path_reg = {path_reg[CODE_BITS_DEF-1:0], stream_bit};
        if (path_reg[CODE_BITS_DEF]) begin
          // path ran past the table: error beat, start a fresh code
          res.sym  = '0;
          res.err  = 1'b1;
          owed_q.push_back(res);
          path_reg = 1;
          n_err++;
        end else if (entry_set[path_reg[CODE_BITS_DEF-1:0]]) begin
          res.sym  = sym_mem[path_reg[CODE_BITS_DEF-1:0]];
          res.err  = 1'b0;
          owed_q.push_back(res);
          path_reg = 1;
          n_sym++;
        end
      end
    endfunction

    // an output beat was accepted: compare with the oldest owed result
    function void check_result(logic [SYM_W-1:0] sym, logic err);
      decode_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, got symbol %02h error %0b",
                 $time, sym, err);
        n_fail++;
      end else begin
        want = owed_q.pop_front();
        if (sym !== want.sym) begin
          $display("%0t: decoded_symbol mismatch, expected %02h, got %02h",
                   $time, want.sym, sym);
          n_fail++;
        end
        if (err !== want.err) begin
          $display("%0t: code_error mismatch, expected %0b, got %0b",
                   $time, want.err, err);
          n_fail++;
        end
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // code_id [14:0], symbol [22:15], bit_req [23]
  logic [IN_DATA_W-1:0] s_tdata;
  // command [0]
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  // decoded_symbol [7:0]
  logic [SYM_W-1:0]     m_tdata;
  // code_error [0]
  logic                 m_tuser;

  decode_scoreboard sb = new();

  int burst_left = 0;  // beats left in the current sender burst
  int n_items    = 0;  // input beats accepted so far
  int rx_mode    = 0;  // receiver stall pattern, changed per phase
  int hold_reqs  = 0;  // long hold-offs asked for by the sender side

  huffman_code_table_decoder u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #6 clk = ~clk;

  // generous hard stop, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // both monitors sample at the edge; inputs are noted before outputs checked
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_beat(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    end
  end

  // receiver: stall pattern per phase, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    int hold_seen;
    int rx_cnt;
    hold_left = 0;
    hold_seen = 0;
    rx_cnt    = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cnt++;
      if (hold_reqs != hold_seen) begin
        // hold off long enough that the output register fills and input stalls
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          2:       m_tready <= (rx_cnt % 5 != 2);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // offer one beat and wait for it to be taken; bursts with random gaps
  task automatic push_beat(input logic cmd, input logic stream_bit,
                           input logic [ID_W-1:0] id, input logic [SYM_W-1:0] sym);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {stream_bit, sym, id};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
  endtask

  // table write; the unused stream bit carries random content
  task automatic load_entry(input int id, input logic [SYM_W-1:0] sym);
    push_beat(hctd_pkg::CMD_LOAD, 1'($urandom_range(0, 1)), ID_W'(id), sym);
  endtask

  // one stream bit; unused id and symbol fields carry random content
  task automatic decode_bit(input logic stream_bit);
    push_beat(hctd_pkg::CMD_DECODE, stream_bit, ID_W'($urandom_range(0, TBL_SIZE - 1)),
              SYM_W'($urandom_range(0, 255)));
  endtask

  // send the code bits of an id, msb first, skipping the leading 1
  task automatic send_code(input int id);
    int nb;
    nb = 0;
    while ((id >> (nb + 1)) != 0) nb++;
    for (int k = nb - 1; k >= 0; k--) decode_bit(1'((id >> k) & 1));
  endtask

  // stop offering until every owed result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int root;
    int node;
    int idx;
    int n_codes;
    int run_len;
    int pick;
    int p;
    int leaf_q[$];
    logic [SYM_W-1:0] leaf_sym[$];

    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= hctd_pkg::CMD_LOAD;
    s_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part; the first beat waits out the valid-map clearing sweep
    // ids zero and one are stored but can never be reached by a path
    load_entry(0, 8'h3C);
    load_entry(1, 8'hC3);
    // deepest entry (all ones) written, then rewritten with a new symbol
    load_entry(TBL_SIZE - 1, 8'hFF);
    load_entry(TBL_SIZE - 1, 8'h00);
    repeat (CODE_BITS_DEF - 1) decode_bit(1'b1);
    // a path that hits nothing runs past the table and gives the error beat
    decode_bit(1'b1);
    repeat (CODE_BITS_DEF - 1) decode_bit(1'b0);
    drain();

    // random phases: each builds a small prefix code in a subtree of its own
    // under the leading 0 bit, so codes of old phases never shadow new ones
    p = 0;
    while (n_items < N_ITEMS) begin
      rx_mode = (p == 0) ? 0 : $urandom_range(0, 3);
      root = (2 << 5) | (p % 32);
      leaf_q.delete();
      leaf_sym.delete();
      leaf_q.push_back(root);
      repeat ($urandom_range(1, 7)) begin
        idx  = $urandom_range(0, leaf_q.size() - 1);
        node = leaf_q[idx];
        if (node < (root << 6)) begin
          leaf_q.delete(idx);
          leaf_q.push_back(2 * node);
          leaf_q.push_back(2 * node + 1);
        end
      end
      foreach (leaf_q[i]) leaf_sym.push_back(SYM_W'($urandom_range(0, 255)));
      // make sure both symbol extremes are loaded in the first phase
      if (p == 0) begin
        leaf_sym[0] = 8'hFF;
        leaf_sym[1] = 8'h00;
      end
      foreach (leaf_q[i]) load_entry(leaf_q[i], leaf_sym[i]);
      // sometimes rewrite one leaf before decoding
      if ($urandom_range(0, 1) == 1) begin
        idx = $urandom_range(0, leaf_q.size() - 1);
        leaf_sym[idx] = SYM_W'($urandom_range(0, 255));
        load_entry(leaf_q[idx], leaf_sym[idx]);
      end

      // receiver holds off while the sender keeps pushing codes
      if (p == 1) hold_reqs++;

      n_codes = $urandom_range(10, 25);
      repeat (n_codes) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          // noise run on the 1 side: usually a full overflow, sometimes partial
          run_len = ($urandom_range(0, 1) == 1) ? CODE_BITS_DEF : $urandom_range(1, 20);
          decode_bit(1'b1);
          repeat (run_len - 1) decode_bit(1'($urandom_range(0, 1)));
        end else if (pick == 1) begin
          // stray deep load anywhere from id 256 to the top of the table
          load_entry($urandom_range(256, TBL_SIZE - 1), SYM_W'($urandom_range(0, 255)));
        end else begin
          send_code(leaf_q[$urandom_range(0, leaf_q.size() - 1)]);
        end
      end
      drain();
      p++;
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (sb.pending() > 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.n_fail++;
    end

    $display("ran %0d phases: %0d table loads, %0d stream bits", p, sb.n_load, sb.n_decode);
    $display("checked %0d decoded symbols and %0d overflow errors, %0d failures",
             sb.n_sym, sb.n_err, sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hctd_pkg.sv
hw/rtl/hctd_table.sv
hw/rtl/huffman_code_table_decoder.sv
verif/testbench.sv
